>>> design/serial_clock_chip_with_pram_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial clock chip
// Each macro checks one implication on clk_i, with rst_ni low disabling it.
// ----------------------------------------------------------------------------
`ifndef SERIAL_CLOCK_CHIP_WITH_PRAM_MACROS_SVH
`define SERIAL_CLOCK_CHIP_WITH_PRAM_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SCC_ASSERT_IMP(lbl, ante, cons)
`define SCC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> design/scc_pkg.sv
// ----------------------------------------------------------------------------
// Serial clock chip package
// Payload structs, the memory request struct and shared constants.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Default size of the parameter memory in bytes.
  localparam int unsigned MEMORY_BYTES_DEFAULT = 256;

  // Input item: one serial bit transfer.
  typedef struct packed {
    logic        operation;
    logic        data_bit;
    logic [31:0] host_seconds;
  } in_t;

  // Result item for one serial bit transfer.
  typedef struct packed {
    logic reply_bit;
    logic command_done;
  } out_t;

  // Request from the command logic to the parameter memory.
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

endpackage

>>> design/scc_pram.sv
// ----------------------------------------------------------------------------
// Parameter memory
// Single-port byte memory with registered read data and per-entry valid bits
// so that entries not written since reset read as zero.
// ----------------------------------------------------------------------------
module scc_pram #(
  parameter int unsigned MEMORY_BYTES = scc_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_pkg::mem_req_t req_i,
  output logic [7:0]        rd_data_o
);

  localparam int unsigned AW = $clog2(MEMORY_BYTES);

  logic [7:0]              mem_q [MEMORY_BYTES];
  logic [MEMORY_BYTES-1:0] valid_q;
  logic [7:0]              rd_data_q;
  logic                    rd_valid_q;
  logic [AW-1:0]           idx;

  assign idx = AW'(req_i.addr);

  // Storage array, no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[idx] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[idx];
    end
  end

  // Valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[idx] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[idx];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : 8'h00;

endmodule

>>> design/scc_ctrl.sv
// ----------------------------------------------------------------------------
// Serial command logic
// Assembles command bytes from serial bits, decodes and runs commands and
// shifts the latched reply byte out one bit per transfer.
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  scc_pkg::in_t      item_i,
  input  logic [7:0]        rd_data_i,
  output scc_pkg::mem_req_t req_o,
  output scc_pkg::out_t     res_o
);

  // Count of complete bytes held for the pending command.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  localparam logic [7:0]  EXT_MASK     = 8'hB8;
  localparam logic [7:0]  EXT_READ     = 8'hB8;
  localparam logic [7:0]  EXT_WRITE    = 8'h38;
  localparam logic [31:0] EPOCH_OFFSET = 32'd2082844800;
  localparam logic [7:0]  CLOCK_LIMIT  = 8'd8;

  logic [7:0] shift_q, shift_d;
  logic [2:0] in_cnt_q, in_cnt_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] addr_q, addr_d;
  logic [1:0] held_q, held_d;
  logic [7:0] reply_q, reply_d;
  logic       use_mem_q, use_mem_d;
  logic [2:0] out_cnt_q, out_cnt_d;

  logic [7:0]  reply_cur;
  logic [7:0]  byte_new;
  logic        do_read;
  logic        do_write;
  logic [7:0]  rd_addr;
  logic [7:0]  wr_addr;
  logic [31:0] seconds;

  function automatic logic is_ext_read(logic [7:0] c);
    return (c & EXT_MASK) == EXT_READ;
  endfunction

  function automatic logic is_ext_write(logic [7:0] c);
    return (c & EXT_MASK) == EXT_WRITE;
  endfunction

  function automatic logic [7:0] ext_address(logic [7:0] c, logic [7:0] p);
    return {c[2:0], p[6:2]};
  endfunction

  function automatic logic [7:0] short_address(logic [7:0] c);
    return {3'b000, c[6:2]};
  endfunction

  // A memory read lands in the memory's output register in the cycle after the request.
  assign reply_cur = use_mem_q ? rd_data_i : reply_q;
  assign byte_new  = shift_q | (8'(item_i.data_bit) << in_cnt_q);
  assign seconds   = item_i.host_seconds + EPOCH_OFFSET;

  // Bit assembly and command decode.
  always_comb begin
    shift_d   = shift_q;
    in_cnt_d  = in_cnt_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    held_d    = held_q;
    reply_d   = reply_q;
    use_mem_d = use_mem_q;
    out_cnt_d = out_cnt_q;
    do_read   = 1'b0;
    do_write  = 1'b0;
    rd_addr   = 8'h00;
    wr_addr   = 8'h00;
    req_o     = '0;
    res_o     = '0;

    if (fire_i) begin
      if (item_i.operation) begin
        res_o.reply_bit = reply_cur[out_cnt_q];
        out_cnt_d       = out_cnt_q + 3'd1;
      end else begin
        in_cnt_d = in_cnt_q + 3'd1;
        if (in_cnt_q == 3'd7) begin
          shift_d = 8'h00;
          case (held_q)
            HELD_NONE: begin
              cmd_d = byte_new;
              if (is_ext_read(byte_new) || is_ext_write(byte_new)) begin
                held_d = HELD_ONE;
              end else if (byte_new[7]) begin
                do_read = 1'b1;
                rd_addr = short_address(byte_new);
              end else begin
                held_d = HELD_ONE;
              end
            end
            HELD_ONE: begin
              if (is_ext_read(cmd_q)) begin
                held_d  = HELD_NONE;
                do_read = 1'b1;
                rd_addr = ext_address(cmd_q, byte_new);
              end else if (is_ext_write(cmd_q)) begin
                addr_d = byte_new;
                held_d = HELD_TWO;
              end else begin
                held_d   = HELD_NONE;
                do_write = 1'b1;
                wr_addr  = short_address(cmd_q);
              end
            end
            HELD_TWO: begin
              held_d = HELD_NONE;
              if (is_ext_write(cmd_q)) begin
                do_write = 1'b1;
                wr_addr  = ext_address(cmd_q, addr_q);
              end
            end
            default: begin
              held_d = HELD_NONE;
            end
          endcase
        end else begin
          shift_d = byte_new;
        end
      end
    end

    // Run a read: the clock bytes come from the adder, the rest from memory.
    if (do_read) begin
      res_o.command_done = 1'b1;
      out_cnt_d          = 3'd0;
      if (rd_addr < CLOCK_LIMIT) begin
        reply_d   = 8'(seconds >> {rd_addr[1:0], 3'b000});
        use_mem_d = 1'b0;
      end else begin
        req_o.re   = 1'b1;
        req_o.addr = rd_addr;
        use_mem_d  = 1'b1;
      end
    end

    // Run a write.
    if (do_write) begin
      res_o.command_done = 1'b1;
      req_o.we           = 1'b1;
      req_o.addr         = wr_addr;
      req_o.wdata        = byte_new;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= 8'h00;
      in_cnt_q  <= 3'd0;
      cmd_q     <= 8'h00;
      addr_q    <= 8'h00;
      held_q    <= HELD_NONE;
      reply_q   <= 8'h00;
      use_mem_q <= 1'b0;
      out_cnt_q <= 3'd0;
    end else begin
      shift_q   <= shift_d;
      in_cnt_q  <= in_cnt_d;
      cmd_q     <= cmd_d;
      addr_q    <= addr_d;
      held_q    <= held_d;
      reply_q   <= reply_d;
      use_mem_q <= use_mem_d;
      out_cnt_q <= out_cnt_d;
    end
  end

endmodule

>>> design/serial_clock_chip_with_pram.sv
// ----------------------------------------------------------------------------
// Serial clock chip with parameter memory: one serial bit per transfer.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one transfer per cycle while the output register is not held by a stall.
// Reset clears the control state; memory entries read as zero until written.
// ----------------------------------------------------------------------------
`include "serial_clock_chip_with_pram_macros.svh"

module serial_clock_chip_with_pram #(
  parameter int unsigned MEMORY_BYTES = scc_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  scc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output scc_pkg::out_t out_data_o
);

  logic              fire;
  scc_pkg::mem_req_t req;
  scc_pkg::out_t     res;
  logic [7:0]        rd_data;
  logic              out_valid_q, out_valid_d;
  scc_pkg::out_t     out_data_q;

  // The output register frees as soon as its result transfers.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  scc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_data_i),
    .rd_data_i (rd_data),
    .req_o     (req),
    .res_o     (res)
  );

  scc_pram #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_pram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the command logic and output register.
  `SCC_ASSERT_IMP(a_one_mem_access, req.we || req.re, fire && !(req.we && req.re))
  `SCC_ASSERT_NXT(a_result_follows, fire, out_valid_o)
  `SCC_ASSERT_NXT(a_reply_not_done, fire && in_data_i.operation, !out_data_o.command_done)

endmodule

>>> sim/scc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial clock chip testbench package
// Operation codes, command byte decoding and constants shared by the
// stimulus in the top level and the checker.
// ----------------------------------------------------------------------------
package scc_tb_pkg;

  // What one transfer does on the serial link.
  typedef enum logic {
    OP_SHIFT_IN  = 1'b0,
    OP_SHIFT_OUT = 1'b1
  } op_e;

  // Kinds of command, decoded from the first byte.
  typedef enum logic [1:0] {
    CMD_SHORT_WRITE,
    CMD_SHORT_READ,
    CMD_EXT_WRITE,
    CMD_EXT_READ
  } cmd_kind_e;

  localparam logic [7:0]  EXT_MASK       = 8'hB8;
  localparam logic [7:0]  EXT_READ_CODE  = 8'hB8;
  localparam logic [7:0]  EXT_WRITE_CODE = 8'h38;
  localparam logic [7:0]  READ_FLAG      = 8'h80;
  // Seconds between the 1904 and 1970 epochs.
  localparam logic [31:0] EPOCH_OFFSET   = 32'd2082844800;
  // Addresses below this read the seconds count instead of memory.
  localparam int unsigned CLOCK_BYTES    = 8;

  // Extended patterns take priority over the read flag.
  function automatic cmd_kind_e command_kind(logic [7:0] c);
    if ((c & EXT_MASK) == EXT_READ_CODE) return CMD_EXT_READ;
    if ((c & EXT_MASK) == EXT_WRITE_CODE) return CMD_EXT_WRITE;
    if ((c & READ_FLAG) != 8'h00) return CMD_SHORT_READ;
    return CMD_SHORT_WRITE;
  endfunction

endpackage

>>> sim/scc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial clock chip checker
// Watches both channels, predicts the result of every input transfer with its
// own model of the chip and compares each output transfer in order.
// ----------------------------------------------------------------------------
module scc_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  scc_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  scc_pkg::out_t out_data_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   pending_o
);

  // Number of complete bytes of the command being gathered.
  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_ONE,
    HELD_TWO
  } held_e;

  // Model state.
  logic [7:0] rx_byte;
  logic [2:0] rx_count;
  logic [7:0] cmd_byte;
  logic [7:0] addr_byte;
  held_e      held;
  logic [7:0] tx_byte;
  logic [2:0] tx_count;
  logic [7:0] pram_model [256];

  scc_pkg::out_t expected_q [$];
  int unsigned   mismatch_total;
  int unsigned   result_index;

  // State after reset: everything zero, memory cleared.
  task automatic reset_model();
    rx_byte   = '0;
    rx_count  = '0;
    cmd_byte  = '0;
    addr_byte = '0;
    held      = HELD_NONE;
    tx_byte   = '0;
    tx_count  = '0;
    foreach (pram_model[i]) pram_model[i] = '0;
    expected_q.delete();
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, result_index, msg);
    mismatch_total++;
  endtask

  function automatic logic [7:0] ext_address(logic [7:0] c, logic [7:0] p);
    return {c[2:0], p[6:2]};
  endfunction

  // Low addresses return one byte of the 1904-based seconds count.
  function automatic logic [7:0] read_location(logic [7:0] addr, logic [31:0] host);
    logic [31:0] clock_secs;
    clock_secs = host + scc_tb_pkg::EPOCH_OFFSET;
    if (addr < scc_tb_pkg::CLOCK_BYTES) return clock_secs[addr[1:0] * 8 +: 8];
    return pram_model[addr];
  endfunction

  // Advance the model by one transfer and return the result it causes.
  function automatic scc_pkg::out_t predict_transfer(scc_pkg::in_t it);
    scc_pkg::out_t res;
    logic [7:0]    full;
    res = '0;
    if (it.operation == scc_tb_pkg::OP_SHIFT_OUT) begin
      res.reply_bit = tx_byte[tx_count];
      tx_count++;
      return res;
    end

    // Gather command bits, least significant first.
    rx_byte[rx_count] = it.data_bit;
    rx_count++;
    if (rx_count != 3'd0) return res;
    full    = rx_byte;
    rx_byte = '0;

    case (held)
      HELD_NONE: begin
        cmd_byte = full;
        if (scc_tb_pkg::command_kind(full) == scc_tb_pkg::CMD_SHORT_READ) begin
          tx_byte = read_location({3'b000, full[6:2]}, it.host_seconds);
          tx_count = '0;
          res.command_done = 1'b1;
        end else begin
          held = HELD_ONE;
        end
      end
      HELD_ONE: begin
        case (scc_tb_pkg::command_kind(cmd_byte))
          scc_tb_pkg::CMD_EXT_READ: begin
            held     = HELD_NONE;
            tx_byte  = read_location(ext_address(cmd_byte, full), it.host_seconds);
            tx_count = '0;
            res.command_done = 1'b1;
          end
          scc_tb_pkg::CMD_EXT_WRITE: begin
            addr_byte = full;
            held      = HELD_TWO;
          end
          default: begin
            held = HELD_NONE;
            pram_model[{3'b000, cmd_byte[6:2]}] = full;
            res.command_done = 1'b1;
          end
        endcase
      end
      HELD_TWO: begin
        // Only an extended write has a third byte; anything else is dropped.
        held = HELD_NONE;
        if (scc_tb_pkg::command_kind(cmd_byte) == scc_tb_pkg::CMD_EXT_WRITE) begin
          pram_model[ext_address(cmd_byte, addr_byte)] = full;
          res.command_done = 1'b1;
        end
      end
      default: held = HELD_NONE;
    endcase
    return res;
  endfunction

  // Compare each output transfer with the oldest expectation, then predict
  // the input transfer of the same edge.
  always @(posedge clk_i) begin
    scc_pkg::out_t want;
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %b with no transfer waiting", out_data_i));
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.reply_bit !== want.reply_bit) begin
            report_mismatch($sformatf("reply_bit got %b want %b",
                                      out_data_i.reply_bit, want.reply_bit));
          end
          if (out_data_i.command_done !== want.command_done) begin
            report_mismatch($sformatf("command_done got %b want %b",
                                      out_data_i.command_done, want.command_done));
          end
        end
        result_index++;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.insert(expected_q.size(), predict_transfer(in_data_i));
      end
    end
    pending_o        <= expected_q.size();
    mismatch_count_o <= mismatch_total;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial clock chip testbench top
// Drives bit transfers built into short, extended and broken commands, with
// bursty input and patterned output stalls, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RANDOM_ITEMS    = 900;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_AT_ITEM    = 300;
  localparam int unsigned PAUSE_AT_ITEM   = 600;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  scc_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  scc_pkg::out_t out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  // Sender bookkeeping.
  int unsigned burst_left  = 0;
  int unsigned items_sent  = 0;
  logic [2:0]  bit_phase   = '0;
  logic        hold_req    = 1'b0;
  logic        hold_served = 1'b0;

  always #1 clk = ~clk;

  serial_clock_chip_with_pram DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  scc_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // Host time: mostly random, with the extremes and the 32-bit wrap point.
  function automatic logic [31:0] pick_host();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0 - scc_tb_pkg::EPOCH_OFFSET + $urandom_range(0, 3) - 2;
      default: return $urandom;
    endcase
  endfunction

  // Addresses cluster low so that reads hit earlier writes and the clock.
  function automatic logic [7:0] pick_address();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom);
      1:       return 8'hF8 | 8'($urandom_range(0, 7));
      default: return 8'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One input transfer; gaps come between bursts of random length.
  task automatic send_item(logic op, logic dbit, logic [31:0] host);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, data_bit: dbit, host_seconds: host};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
    if (op == scc_tb_pkg::OP_SHIFT_IN) bit_phase++;
  endtask

  task automatic send_byte(logic [7:0] b, logic [31:0] host);
    for (int i = 0; i < 8; i++) send_item(scc_tb_pkg::OP_SHIFT_IN, b[i], host);
  endtask

  // Reply bits carry a random data bit, which the chip ignores.
  task automatic read_reply(int unsigned n);
    repeat (n) send_item(scc_tb_pkg::OP_SHIFT_OUT, 1'($urandom), pick_host());
  endtask

  // One well-formed command with random kind and content.
  task automatic send_command();
    scc_tb_pkg::cmd_kind_e kind;
    logic [7:0]            addr;
    logic [7:0]            c;
    logic [7:0]            p;
    kind = scc_tb_pkg::cmd_kind_e'($urandom_range(0, 3));
    addr = pick_address();
    c    = 8'($urandom);
    p    = 8'($urandom);
    if (kind == scc_tb_pkg::CMD_EXT_READ || kind == scc_tb_pkg::CMD_EXT_WRITE) begin
      c = c | scc_tb_pkg::EXT_MASK;
      if (kind == scc_tb_pkg::CMD_EXT_WRITE) c[7] = 1'b0;
      c[2:0] = addr[7:5];
      p[6:2] = addr[4:0];
    end else begin
      c[6:2] = addr[4:0];
      c[7]   = (kind == scc_tb_pkg::CMD_SHORT_READ);
      // This address pattern would decode as an extended command.
      if (scc_tb_pkg::command_kind(c) != kind) c[3] = 1'b0;
    end

    // Pad to a byte boundary after noise left a partial byte.
    while (bit_phase != 3'd0) begin
      send_item(scc_tb_pkg::OP_SHIFT_IN, 1'($urandom), pick_host());
    end

    send_byte(c, pick_host());
    if (kind == scc_tb_pkg::CMD_SHORT_WRITE) send_byte(pick_data(), pick_host());
    if (kind == scc_tb_pkg::CMD_EXT_READ || kind == scc_tb_pkg::CMD_EXT_WRITE) begin
      send_byte(p, pick_host());
    end
    if (kind == scc_tb_pkg::CMD_EXT_WRITE) send_byte(pick_data(), pick_host());
    if (kind == scc_tb_pkg::CMD_SHORT_READ || kind == scc_tb_pkg::CMD_EXT_READ) begin
      read_reply(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 8);
    end
  endtask

  // Receiver: randomly chosen stall modes, plus one long
  // hold-off so the chip fills up and stalls its input.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= (phase % 4 == 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    bit paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reply bits before any read shift out the zero reply byte.
    read_reply(2);
    // Short read of the top seconds byte at maximum host time, then one
    // reply bit past the byte to show the bit counter wrap.
    send_byte(scc_tb_pkg::READ_FLAG | (8'd3 << 2), 32'hFFFF_FFFF);
    read_reply(9);

    while (items_sent < RANDOM_ITEMS + 19) begin
      if (items_sent >= HOLD_AT_ITEM) hold_req = 1'b1;
      if (items_sent >= PAUSE_AT_ITEM && !paused) begin
        // Let the chip drain completely before going on.
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        burst_left = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        // Noise: random bits that break byte alignment and command framing.
        repeat ($urandom_range(1, 12)) begin
          send_item(1'($urandom), 1'($urandom), pick_host());
        end
      end else begin
        send_command();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
